@@ hdl/swscrc_pkg.sv @@
// Shared types, codes and the CRC-32 byte step for the write-session block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package swscrc_pkg;

	// opcodes
	localparam logic [2:0] OP_BEGIN  = 3'd0;
	localparam logic [2:0] OP_HEADER = 3'd1;
	localparam logic [2:0] OP_BYTE   = 3'd2;
	localparam logic [2:0] OP_END    = 3'd3;
	localparam logic [2:0] OP_WIPE   = 3'd4;

	// status codes
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_SEQ   = 3'd1;
	localparam logic [2:0] ST_RANGE = 3'd2;
	localparam logic [2:0] ST_WFAIL = 3'd3;
	localparam logic [2:0] ST_CRC   = 3'd4;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [15:0] packet_seq;
		logic [15:0] chunk_length;
		logic [7:0]  data_byte;
		logic [31:0] word_value;
		logic        flash_ok;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] next_seq;
		logic        program_valid;
		logic [19:0] program_offset;
		logic [7:0]  program_byte;
		logic        chunk_done;
		logic        commit;
		logic [31:0] final_crc;
		logic [20:0] file_size;
	} result_t;

	// pipeline flow control shared by the stage registers
	typedef struct packed {
		logic s1_valid;  // input stage holds a word
		logic advance;   // input stage moves into the result register
	} flow_t;

	// reflected CRC-32, one byte
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = {24'h0, crc[7:0] ^ b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
		end
		return c ^ (crc >> 8);
	endfunction

endpackage

@@ hdl/swscrc_in_reg.sv @@
// Input stage register for the write-session block.
// Depends on swscrc_pkg (item_t, flow_t).
`timescale 1ns / 1ps

module swscrc_in_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  swscrc_pkg::item_t   item,
	input  swscrc_pkg::flow_t   flow,
	output logic                item_stall,
	output logic                valid_s1,
	output swscrc_pkg::item_t   item_s1
);
	import swscrc_pkg::*;

	// full and not draining this cycle
	assign item_stall = flow.s1_valid && !flow.advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

endmodule

@@ hdl/swscrc_session.sv @@
// Session state and per-word decode: sequence, range, CRC and commit checks.
// Depends on swscrc_pkg (item_t, result_t, codes, crc32_byte).
`timescale 1ns / 1ps

module swscrc_session #(
	parameter int MAX_FILE_BYTES  = 1048576,
	parameter int CHUNK_MAX_BYTES = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  swscrc_pkg::item_t   item,
	output swscrc_pkg::result_t result
);
	import swscrc_pkg::*;

	localparam int TOT_W = $clog2(MAX_FILE_BYTES + 1);
	localparam int LEN_W = $clog2(CHUNK_MAX_BYTES + 1);
	localparam int SUM_W = ((TOT_W > 16) ? TOT_W : 16) + 1;

	logic             active_q, active_d;
	logic [TOT_W-1:0] total_q, total_d;
	logic [TOT_W-1:0] offset_q, offset_d;
	logic [15:0]      seq_q, seq_d;
	logic [31:0]      crc_q, crc_d;
	logic [LEN_W-1:0] left_q, left_d;

	logic [SUM_W-1:0] end_sum;
	logic [31:0]      crc_fin;

	assign end_sum = SUM_W'(offset_q) + SUM_W'(item.chunk_length);
	assign crc_fin = crc_q ^ CRC_ONES;

	always_comb begin
		active_d = active_q;
		total_d  = total_q;
		offset_d = offset_q;
		seq_d    = seq_q;
		crc_d    = crc_q;
		left_d   = left_q;
		result   = '0;
		result.status = ST_OK;

		unique case (item.opcode)
			OP_BEGIN: begin
				if (item.word_value == 32'd0 ||
				    item.word_value > 32'(MAX_FILE_BYTES)) begin
					result.status = ST_RANGE;
				end else if (!item.flash_ok) begin
					active_d = 1'b0;
					left_d   = '0;
					result.status = ST_WFAIL;
				end else begin
					active_d = 1'b1;
					total_d  = item.word_value[TOT_W-1:0];
					offset_d = '0;
					seq_d    = '0;
					crc_d    = CRC_ONES;
					left_d   = '0;
				end
			end
			OP_HEADER: begin
				if (!active_q || left_q != '0 || item.packet_seq != seq_q) begin
					result.status = ST_SEQ;
				end else if (item.chunk_length == 16'd0 ||
				             32'(item.chunk_length) > 32'(CHUNK_MAX_BYTES) ||
				             end_sum > SUM_W'(total_q)) begin
					result.status = ST_RANGE;
				end else begin
					left_d = item.chunk_length[LEN_W-1:0];
				end
			end
			OP_BYTE: begin
				if (!active_q || left_q == '0) begin
					result.status = ST_SEQ;
				end else begin
					result.program_valid  = 1'b1;
					result.program_offset = 20'(offset_q);
					result.program_byte   = item.data_byte;
					if (!item.flash_ok) begin
						active_d = 1'b0;
						left_d   = '0;
						result.status = ST_WFAIL;
					end else begin
						crc_d    = crc32_byte(crc_q, item.data_byte);
						offset_d = offset_q + TOT_W'(1);
						left_d   = left_q - LEN_W'(1);
						if (left_q == LEN_W'(1)) begin
							seq_d = seq_q + 16'd1;
							result.chunk_done = 1'b1;
						end
					end
				end
			end
			OP_END: begin
				if (!active_q) begin
					result.status = ST_SEQ;
				end else begin
					active_d = 1'b0;
					left_d   = '0;
					if (offset_q != total_q) begin
						result.status = ST_SEQ;
					end else if (crc_fin != item.word_value) begin
						result.status = ST_CRC;
					end else begin
						result.commit    = 1'b1;
						result.final_crc = crc_fin;
						result.file_size = 21'(32'(total_q) & 32'h001F_FFFF);
					end
				end
			end
			OP_WIPE: begin
				if (!item.flash_ok) begin
					result.status = ST_WFAIL;
				end else begin
					active_d = 1'b0;
					total_d  = '0;
					offset_d = '0;
					seq_d    = '0;
					crc_d    = '0;
					left_d   = '0;
				end
			end
			default: begin
				result.status = ST_RANGE;
			end
		endcase

		result.next_seq = seq_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			total_q  <= '0;
			offset_q <= '0;
			seq_q    <= '0;
			crc_q    <= '0;
			left_q   <= '0;
		end else if (advance) begin
			active_q <= active_d;
			total_q  <= total_d;
			offset_q <= offset_d;
			seq_q    <= seq_d;
			crc_q    <= crc_d;
			left_q   <= left_d;
		end
	end

endmodule

@@ hdl/swscrc_out_reg.sv @@
// Result register of the write-session block, held while the sink stalls.
// Depends on swscrc_pkg (result_t).
`timescale 1ns / 1ps

module swscrc_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  swscrc_pkg::result_t next_result,
	input  logic                result_stall,
	output logic                result_valid,
	output swscrc_pkg::result_t result
);
	import swscrc_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result <= next_result;
		end
	end

endmodule

@@ hdl/sequenced_write_session_crc32.sv @@
// Top level of the sequenced file-write session with CRC-32.
// Depends on swscrc_pkg, swscrc_in_reg, swscrc_session, swscrc_out_reg.
`timescale 1ns / 1ps
//
//  channel  | handshake                  | word
//  ---------+----------------------------+----------------------------------
//  item     | item_valid / item_stall    | opcode, seq, length, byte, word, ok
//  result   | result_valid / result_stall| status, seq, program, commit, crc
//
// One word in, one word out. A word is held in the input register while the
// session logic decodes it, and state is updated at the edge that loads the
// result register; one word per cycle sustained while result_stall is low.
// The CRC step is one byte per cycle while the pipeline advances, eight bit steps deep in logic.
// arst_n clears session state and both valid flags; no clearing pass.
// A stalled result holds; the input register still takes one more word,
// then item_stall rises until the result drains.

module sequenced_write_session_crc32 #(
	parameter int MAX_FILE_BYTES  = 1048576,
	parameter int CHUNK_MAX_BYTES = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  swscrc_pkg::item_t   item,
	output logic                result_valid,
	input  logic                result_stall,
	output swscrc_pkg::result_t result
);
	import swscrc_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	result_t next_result;
	flow_t   flow;

	// the input stage drains whenever the result register is free or emptying
	assign flow.s1_valid = valid_s1;
	assign flow.advance  = valid_s1 && !(result_valid && result_stall);

	swscrc_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.flow       (flow),
		.item_stall (item_stall),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	// state moves only on advance, so the next word sees this word's effect
	swscrc_session #(
		.MAX_FILE_BYTES  (MAX_FILE_BYTES),
		.CHUNK_MAX_BYTES (CHUNK_MAX_BYTES)
	) u_session (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (flow.advance),
		.item    (item_s1),
		.result  (next_result)
	);

	swscrc_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (flow.advance),
		.next_result  (next_result),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result)
	);

	// an accepted word is in the input stage on the next cycle
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> valid_s1)
		else $error("accepted word did not reach input stage");

	// result valid drops only after its handshake
	a_result_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(result_valid) |-> $past(!result_stall))
		else $error("result dropped while stalled");

	// a commit is a clean end: ok status, no program request, no chunk end
	a_commit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.commit) |->
		(result.status == ST_OK && !result.program_valid && !result.chunk_done))
		else $error("commit with bad status or program request");

	// chunk end only on a programmed byte
	a_chunk_done: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.chunk_done) |->
		(result.program_valid && result.status == ST_OK))
		else $error("chunk end without programmed byte");

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for sequenced_write_session_crc32: directed and random
// write sessions, a word-level session predictor and an in-order result check.
// Depends on swscrc_pkg and the block's RTL only.
`timescale 1ns / 1ps

module testbench;
	import swscrc_pkg::*;

	localparam logic [31:0] MAX_BYTES    = 32'd1048576;
	localparam logic [15:0] CHUNK_MAX    = 16'd256;
	localparam int unsigned QUIET_LIMIT  = 2000;  // cycles with no word accepted
	localparam int unsigned PHASE_WORDS  = 550;   // queue fill level for each random phase
	localparam logic [2:0]  OP_SPARE_LO  = 3'd5;  // first unused opcode
	localparam logic [2:0]  OP_SPARE_HI  = 3'd7;  // last unused opcode

	// ways a generated session is broken on purpose
	typedef enum int {
		F_NONE, F_BAD_CRC, F_SHORT, F_PROG_FAIL, F_BAD_SEQ, F_WIPE, F_BAD_LEN, F_STRAY
	} fault_e;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	sequenced_write_session_crc32 #(
		.MAX_FILE_BYTES (1048576),
		.CHUNK_MAX_BYTES(256)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	initial forever #4 clk = ~clk;

	// words waiting to be sent, and results owed by the block, oldest first
	item_t       pending_words[$];
	result_t     expected_results[$];
	result_t     want_word;
	int          errors = 0;
	int unsigned quiet_cycles = 0;
	int          send_idle_pct = 20;
	int          recv_stall_pct = 77;

	// predicted session state
	logic        sess_open   = 1'b0;
	logic [20:0] total_bytes = '0;
	logic [20:0] wr_offset   = '0;
	logic [15:0] exp_seq     = '0;
	logic [31:0] crc_reg     = '0;
	logic [8:0]  bytes_left  = '0;

	// reflected CRC-32, one byte, bit at a time over the full register
	function automatic logic [31:0] crc32_fold(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h0, b};
		for (int k = 0; k < 8; k++)
			c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
		return c;
	endfunction

	// Advance the predicted session by one input word and return the result it owes.
	function automatic result_t session_step(input item_t w);
		result_t     r;
		logic [31:0] reach;
		r = '0;
		r.status = ST_OK;
		reach = 32'(wr_offset) + 32'(w.chunk_length);
		case (w.opcode)
			OP_BEGIN: begin
				if (w.word_value == 32'd0 || w.word_value > MAX_BYTES) begin
					r.status = ST_RANGE;  // erase outcome ignored
				end else if (!w.flash_ok) begin
					sess_open  = 1'b0;
					bytes_left = '0;
					r.status   = ST_WFAIL;
				end else begin
					sess_open   = 1'b1;
					total_bytes = w.word_value[20:0];
					wr_offset   = '0;
					exp_seq     = '0;
					crc_reg     = CRC_ONES;
					bytes_left  = '0;
				end
			end
			OP_HEADER: begin
				if (!sess_open || bytes_left != 0 || w.packet_seq != exp_seq)
					r.status = ST_SEQ;
				else if (w.chunk_length == 16'd0 || w.chunk_length > CHUNK_MAX ||
						reach > 32'(total_bytes))
					r.status = ST_RANGE;
				else
					bytes_left = w.chunk_length[8:0];
			end
			OP_BYTE: begin
				if (!sess_open || bytes_left == 0) begin
					r.status = ST_SEQ;
				end else begin
					// request is shown even when the program then fails
					r.program_valid  = 1'b1;
					r.program_offset = wr_offset[19:0];
					r.program_byte   = w.data_byte;
					if (!w.flash_ok) begin
						sess_open  = 1'b0;
						bytes_left = '0;
						r.status   = ST_WFAIL;
					end else begin
						crc_reg    = crc32_fold(crc_reg, w.data_byte);
						wr_offset  = wr_offset + 21'd1;
						bytes_left = bytes_left - 9'd1;
						if (bytes_left == 0) begin
							exp_seq      = exp_seq + 16'd1;
							r.chunk_done = 1'b1;
						end
					end
				end
			end
			OP_END: begin
				if (!sess_open) begin
					r.status = ST_SEQ;
				end else begin
					if (wr_offset != total_bytes) begin
						r.status = ST_SEQ;
					end else if ((crc_reg ^ CRC_ONES) != w.word_value) begin
						r.status = ST_CRC;
					end else begin
						r.commit    = 1'b1;
						r.final_crc = crc_reg ^ CRC_ONES;
						r.file_size = total_bytes;
					end
					sess_open  = 1'b0;
					bytes_left = '0;
				end
			end
			OP_WIPE: begin
				if (!w.flash_ok) begin
					r.status = ST_WFAIL;
				end else begin
					sess_open   = 1'b0;
					total_bytes = '0;
					wr_offset   = '0;
					exp_seq     = '0;
					crc_reg     = '0;
					bytes_left  = '0;
				end
			end
			default: r.status = ST_RANGE;
		endcase
		r.next_seq = exp_seq;
		return r;
	endfunction

	function automatic item_t mk_word(input logic [2:0] op, input logic [15:0] seq,
			input logic [15:0] len, input logic [7:0] b, input logic [31:0] v,
			input logic ok);
		item_t w;
		w.opcode       = op;
		w.packet_seq   = seq;
		w.chunk_length = len;
		w.data_byte    = b;
		w.word_value   = v;
		w.flash_ok     = ok;
		return w;
	endfunction

	function automatic void queue_word(input item_t w);
		pending_words.push_back(w);
	endfunction

	// One write session: begin, chunks of header plus bytes, then end, optionally broken.
	task automatic queue_session(input int unsigned nbytes, input int unsigned max_chunk,
			input fault_e fault);
		int unsigned done_bytes, stop_at, fail_at, len, seq;
		logic [31:0] crc;
		logic [7:0]  b;
		done_bytes = 0;
		seq        = 0;
		crc        = CRC_ONES;
		stop_at    = (fault == F_SHORT || fault == F_WIPE) ? $urandom_range(0, nbytes - 1)
		                                                   : nbytes;
		fail_at    = (fault == F_PROG_FAIL) ? $urandom_range(0, nbytes - 1) : nbytes;
		queue_word(mk_word(OP_BEGIN, $urandom, $urandom, $urandom, nbytes, 1'b1));
		while (done_bytes < stop_at) begin
			len = $urandom_range(1, (nbytes - done_bytes < max_chunk) ? nbytes - done_bytes
			                                                          : max_chunk);
			if (fault == F_BAD_SEQ && $urandom_range(1))
				queue_word(mk_word(OP_HEADER, seq + $urandom_range(1, 65535), len, 0, 0,
					$urandom_range(1)));
			if (fault == F_BAD_LEN && $urandom_range(1))
				queue_word(mk_word(OP_HEADER, seq, nbytes - done_bytes + $urandom_range(1, 300),
					0, 0, $urandom_range(1)));
			queue_word(mk_word(OP_HEADER, seq, len, $urandom, $urandom, $urandom_range(1)));
			repeat (len) begin
				b = $urandom;
				if (done_bytes == fail_at) begin
					queue_word(mk_word(OP_BYTE, $urandom, $urandom, b, $urandom, 1'b0));
					return;
				end
				queue_word(mk_word(OP_BYTE, $urandom, $urandom, b, $urandom, 1'b1));
				crc = crc32_fold(crc, b);
				done_bytes++;
			end
			// byte between chunks: no chunk open
			if (fault == F_STRAY && $urandom_range(1))
				queue_word(mk_word(OP_BYTE, 0, 0, $urandom, 0, 1'b1));
			seq++;
		end
		if (fault == F_WIPE)
			queue_word(mk_word(OP_WIPE, $urandom, $urandom, $urandom, $urandom,
				$urandom_range(1)));
		else
			queue_word(mk_word(OP_END, $urandom, $urandom, $urandom,
				(fault == F_BAD_CRC) ? (~crc ^ (32'd1 << $urandom_range(31))) : ~crc,
				$urandom_range(1)));
	endtask

	// Sessions, over half of them well-formed, with small sizes, a few at full chunk size, plus noise.
	task automatic fill_random();
		fault_e fault;
		while (pending_words.size() < PHASE_WORDS) begin
			if ($urandom_range(99) < 25) begin
				repeat ($urandom_range(1, 4))
					queue_word(mk_word($urandom_range(0, 7), $urandom, $urandom, $urandom,
						$urandom_range(1) ? $urandom : $urandom_range(0, 64),
						$urandom_range(1)));
			end else begin
				fault = ($urandom_range(99) < 55) ? F_NONE : fault_e'($urandom_range(1, 7));
				if ($urandom_range(39) == 0)
					queue_session($urandom_range(256, 400), CHUNK_MAX, fault);
				else
					queue_session($urandom_range(1, 24), $urandom_range(1, 16), fault);
			end
		end
	endtask

	// Hold off until every queued word is sent and every owed result has come back.
	task automatic wait_drain();
		do @(negedge clk);
		while (pending_words.size() != 0 || item_valid || expected_results.size() != 0);
	endtask

	task automatic check_field(input string fname, input logic [31:0] e,
			input logic [31:0] a);
		if (a !== e) begin
			$display("%t %s mismatch: expected %h, actual %h", $time, fname, e, a);
			errors++;
		end
	endtask

	// Driver: predict each accepted word, then offer the next one unless idling.
	// The payload only moves when the slot is empty or was just taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				expected_results.push_back(session_step(item));
			if (!item_valid || !item_stall) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					item       <= pending_words.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each accepted result with the oldest owed one, field by field.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					$display("%t unexpected result word: expected none, actual %h",
						$time, result);
					errors++;
				end else begin
					want_word = expected_results.pop_front();
					check_field("status", want_word.status, result.status);
					check_field("next_seq", want_word.next_seq, result.next_seq);
					check_field("program_valid", want_word.program_valid, result.program_valid);
					check_field("program_offset", want_word.program_offset,
						result.program_offset);
					check_field("program_byte", want_word.program_byte, result.program_byte);
					check_field("chunk_done", want_word.chunk_done, result.chunk_done);
					check_field("commit", want_word.commit, result.commit);
					check_field("final_crc", want_word.final_crc, result.final_crc);
					check_field("file_size", want_word.file_size, result.file_size);
				end
			end
			result_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Watchdog: too long without any word moving on either channel.
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		logic [31:0] crc;

		// no session open yet: header, byte and end are all out of sequence
		queue_word(mk_word(OP_HEADER, 0, 1, 0, 0, 1'b1));
		queue_word(mk_word(OP_BYTE, 0, 0, 8'h5A, 0, 1'b1));
		queue_word(mk_word(OP_END, 0, 0, 0, 0, 1'b1));
		// begin size out of range (zero, one past max), then failed erase
		queue_word(mk_word(OP_BEGIN, 0, 0, 0, 32'd0, 1'b1));
		queue_word(mk_word(OP_BEGIN, 0, 0, 0, MAX_BYTES + 32'd1, 1'b0));
		queue_word(mk_word(OP_BEGIN, 0, 0, 0, 32'd3, 1'b0));
		// wipe whose erase fails, unused opcodes
		queue_word(mk_word(OP_WIPE, 0, 0, 0, 0, 1'b0));
		queue_word(mk_word(OP_SPARE_LO, 0, 0, 0, 0, 1'b1));
		queue_word(mk_word(OP_SPARE_HI, 16'hFFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1));
		// largest file: wrong sequence, bad lengths, full chunk, header over open chunk
		queue_word(mk_word(OP_BEGIN, 0, 0, 0, MAX_BYTES, 1'b1));
		queue_word(mk_word(OP_HEADER, 16'hFFFF, 1, 0, 0, 1'b1));
		queue_word(mk_word(OP_HEADER, 0, 0, 0, 0, 1'b1));
		queue_word(mk_word(OP_HEADER, 0, CHUNK_MAX + 16'd1, 0, 0, 1'b1));
		queue_word(mk_word(OP_HEADER, 0, CHUNK_MAX, 0, 0, 1'b1));
		queue_word(mk_word(OP_HEADER, 0, 1, 0, 0, 1'b1));
		// one good byte, then a failed program closes the session
		queue_word(mk_word(OP_BYTE, 0, 0, 8'h00, 0, 1'b1));
		queue_word(mk_word(OP_BYTE, 0, 0, 8'hFF, 0, 1'b0));
		// header past total size, then end short of the total
		queue_word(mk_word(OP_BEGIN, 0, 0, 0, 32'd2, 1'b1));
		queue_word(mk_word(OP_HEADER, 0, 3, 0, 0, 1'b1));
		queue_word(mk_word(OP_HEADER, 0, 1, 0, 0, 1'b1));
		queue_word(mk_word(OP_BYTE, 0, 0, 8'hA5, 0, 1'b1));
		queue_word(mk_word(OP_END, 0, 0, 0, 0, 1'b1));
		// one-byte file: CRC mismatch, then the same file committed
		crc = crc32_fold(CRC_ONES, 8'hFF) ^ CRC_ONES;
		queue_word(mk_word(OP_BEGIN, 0, 0, 0, 32'd1, 1'b1));
		queue_word(mk_word(OP_HEADER, 0, 1, 0, 0, 1'b1));
		queue_word(mk_word(OP_BYTE, 0, 0, 8'hFF, 0, 1'b1));
		queue_word(mk_word(OP_END, 0, 0, 0, crc ^ 32'd1, 1'b1));
		queue_word(mk_word(OP_BEGIN, 0, 0, 0, 32'd1, 1'b1));
		queue_word(mk_word(OP_HEADER, 0, 1, 0, 0, 1'b1));
		queue_word(mk_word(OP_BYTE, 0, 0, 8'hFF, 0, 1'b1));
		queue_word(mk_word(OP_END, 0, 0, 0, crc, 1'b1));
		queue_word(mk_word(OP_WIPE, 0, 0, 0, 0, 1'b1));

		// phase one: sender idles lightly, receiver stalls heavily
		send_idle_pct  = 20;
		recv_stall_pct = 77;
		fill_random();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait_drain();

		// phase two: the other way round
		send_idle_pct  = 77;
		recv_stall_pct = 20;
		fill_random();
		wait_drain();

		// phase three: full rate both sides
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		fill_random();
		wait_drain();

		// let the two-stage pipe settle in case anything stray comes out
		repeat (10) @(negedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
